>>> hdl/rrqps_pkg.sv
// Shared types and constants for the round-robin queue pair scheduler.
// No dependencies; rrqps_front, rrqps_back and the top level refer to this package.
package rrqps_pkg;

	localparam int NUM_QP_DEF      = 16;
	localparam int QUEUE_DEPTH_DEF = 8;

	typedef enum logic [1:0] {
		MODE_ENQ  = 2'd0,
		MODE_ARB  = 2'd1,
		MODE_STAT = 2'd2,
		MODE_NOP  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_ENQ  = 3'd0,
		ST_FULL = 3'd1,
		ST_IDLE = 3'd2,
		ST_SENT = 3'd3,
		ST_LOOP = 3'd4,
		ST_DROP = 3'd5,
		ST_FAIL = 3'd6,
		ST_STAT = 3'd7
	} status_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [3:0]  qp_index;
		logic [15:0] packet_handle;
		logic        pkt_is_request;
		logic        pkt_loopback;
		logic        qp_valid_in;
		logic        req_ready_in;
		logic        resp_ready_in;
		logic        send_failed;
	} cmd_t;

	typedef struct packed {
		mode_t kind;
		logic  qp_ok;
		cmd_t  cmd;
	} job_t;

	typedef struct packed {
		status_t     status;
		logic [3:0]  grant_qp;
		logic [15:0] grant_handle;
		logic        grant_is_request;
		logic [7:0]  pending_total;
		logic [31:0] error_count;
	} rsp_t;

endpackage

>>> hdl/rrqps_if.sv
// Request and result channel interfaces of the queue pair scheduler.
// Plain valid/ready channels; no package dependency.
interface rrqps_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [3:0]  qp_index;
	logic [15:0] packet_handle;
	logic        pkt_is_request;
	logic        pkt_loopback;
	logic        qp_valid_in;
	logic        req_ready_in;
	logic        resp_ready_in;
	logic        send_failed;

	modport source (output valid, mode, qp_index, packet_handle, pkt_is_request,
		pkt_loopback, qp_valid_in, req_ready_in, resp_ready_in, send_failed,
		input ready);
	modport sink (input valid, mode, qp_index, packet_handle, pkt_is_request,
		pkt_loopback, qp_valid_in, req_ready_in, resp_ready_in, send_failed,
		output ready);
endinterface

interface rrqps_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [3:0]  grant_qp;
	logic [15:0] grant_handle;
	logic        grant_is_request;
	logic [7:0]  pending_total;
	logic [31:0] error_count;

	modport source (output valid, status, grant_qp, grant_handle, grant_is_request,
		pending_total, error_count, input ready);
	modport sink (input valid, status, grant_qp, grant_handle, grant_is_request,
		pending_total, error_count, output ready);
endinterface

>>> hdl/rrqps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rrqps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

>>> hdl/rrqps_front.sv
// Front end: accepts requests, classifies them and holds them in a two-entry queue.
// Depends on rrqps_pkg.
module rrqps_front #(
	parameter int NUM_QP = rrqps_pkg::NUM_QP_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  rrqps_pkg::cmd_t cmd,
	output logic            job_valid,
	input  logic            job_ready,
	output rrqps_pkg::job_t job
);
	rrqps_pkg::job_t ent_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;
	rrqps_pkg::job_t new_job;
	logic            push;
	logic            pop;

	always_comb begin
		new_job.kind  = rrqps_pkg::mode_t'(cmd.mode);
		new_job.qp_ok = 32'(cmd.qp_index) < NUM_QP;
		new_job.cmd   = cmd;
	end

	assign cmd_ready = cnt_q != 2'd2;
	assign job_valid = cnt_q != 2'd0;
	assign job       = ent_q[rd_ptr_q];
	assign push      = cmd_valid && cmd_ready;
	assign pop       = job_valid && job_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= new_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end
endmodule

>>> hdl/rrqps_back.sv
// Back end: queue pair FIFOs, active ring and arbitration sequencer with result register.
// Depends on rrqps_pkg and rrqps_ram.
module rrqps_back #(
	parameter int NUM_QP      = rrqps_pkg::NUM_QP_DEF,
	parameter int QUEUE_DEPTH = rrqps_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_valid,
	output logic            job_ready,
	input  rrqps_pkg::job_t job,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output rrqps_pkg::rsp_t rsp
);
	localparam int QW = $clog2(NUM_QP);
	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int FW = $clog2(QUEUE_DEPTH + 1);
	localparam int PD = NUM_QP * QUEUE_DEPTH;
	localparam int AW = $clog2(PD);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RING = 3'b010,
		S_PKT  = 3'b100
	} state_t;

	state_t          state_q, state_d;
	logic [FW-1:0]   fill_q [NUM_QP];
	logic [PW-1:0]   head_q [NUM_QP];
	logic            on_ring_q [NUM_QP];
	logic [2:0]      flags_q [NUM_QP];
	logic [QW-1:0]   ring_head_q, ring_head_d;
	logic [QW:0]     ring_fill_q, ring_fill_d;
	logic [7:0]      pend_q, pend_d;
	logic [31:0]     fail_q, fail_d;
	logic [QW-1:0]   g_q, g_d;
	logic            rsp_valid_q;
	rrqps_pkg::rsp_t rsp_q, rsp_d;
	logic            rsp_load;

	logic [QW-1:0]   qi, sel_q;
	logic [FW-1:0]   fill_sel;
	logic [PW-1:0]   head_sel;
	logic [2:0]      flags_sel;
	logic            onr_sel;
	logic [PW+1:0]   slot_sum;
	logic [PW-1:0]   slot;
	logic [QW+1:0]   tail_sum;
	logic [QW-1:0]   tail;
	logic [AW-1:0]   pkt_base;
	logic            push_ok, can_emit;

	logic            pkt_we, pkt_re;
	logic [AW-1:0]   pkt_waddr, pkt_raddr;
	logic [17:0]     pkt_wdata, pkt_rdata;
	logic            ring_we, ring_re;
	logic [QW-1:0]   ring_waddr, ring_rdata;

	logic            fill_we, head_we, onr_we, flags_we;
	logic [FW-1:0]   fill_wd;
	logic [PW-1:0]   head_wd;
	logic            onr_wd;
	logic            is_req, side_ok, fail_now;
	logic [FW-1:0]   new_fill;

	rrqps_ram #(.WIDTH(18), .DEPTH(PD)) u_pkt_ram (
		.clk(clk), .we(pkt_we), .waddr(pkt_waddr), .wdata(pkt_wdata),
		.re(pkt_re), .raddr(pkt_raddr), .rdata(pkt_rdata)
	);

	rrqps_ram #(.WIDTH(QW), .DEPTH(NUM_QP)) u_ring_ram (
		.clk(clk), .we(ring_we), .waddr(ring_waddr), .wdata(sel_q),
		.re(ring_re), .raddr(ring_head_q), .rdata(ring_rdata)
	);

	always_comb begin
		qi = QW'(job.cmd.qp_index);
		case (state_q)
			S_IDLE:  sel_q = qi;
			S_RING:  sel_q = ring_rdata;
			default: sel_q = g_q;
		endcase
		fill_sel  = fill_q[sel_q];
		head_sel  = head_q[sel_q];
		flags_sel = flags_q[sel_q];
		onr_sel   = on_ring_q[sel_q];
		slot_sum  = (PW+2)'(head_sel) + (PW+2)'(fill_sel);
		slot      = (slot_sum >= (PW+2)'(QUEUE_DEPTH)) ?
			PW'(slot_sum - (PW+2)'(QUEUE_DEPTH)) : PW'(slot_sum);
		tail_sum  = (QW+2)'(ring_head_q) + (QW+2)'(ring_fill_q);
		tail      = (tail_sum >= (QW+2)'(NUM_QP)) ?
			QW'(tail_sum - (QW+2)'(NUM_QP)) : QW'(tail_sum);
		pkt_base  = AW'(AW'(sel_q) * AW'(QUEUE_DEPTH));
		push_ok   = !onr_sel && (ring_fill_q < (QW+1)'(NUM_QP));
		can_emit  = !rsp_valid_q || rsp_ready;
	end

	always_comb begin
		state_d     = state_q;
		job_ready   = 1'b0;
		rsp_load    = 1'b0;
		rsp_d       = '0;
		rsp_d.status = rrqps_pkg::ST_IDLE;
		pkt_we      = 1'b0;
		pkt_re      = 1'b0;
		pkt_waddr   = pkt_base + AW'(slot);
		pkt_raddr   = pkt_base + AW'(head_sel);
		pkt_wdata   = {job.cmd.pkt_loopback, job.cmd.pkt_is_request, job.cmd.packet_handle};
		ring_we     = 1'b0;
		ring_re     = 1'b0;
		ring_waddr  = tail;
		fill_we     = 1'b0;
		fill_wd     = fill_sel;
		head_we     = 1'b0;
		head_wd     = (head_sel == PW'(QUEUE_DEPTH - 1)) ? '0 : head_sel + PW'(1);
		onr_we      = 1'b0;
		onr_wd      = 1'b0;
		flags_we    = 1'b0;
		ring_head_d = ring_head_q;
		ring_fill_d = ring_fill_q;
		pend_d      = pend_q;
		fail_d      = fail_q;
		g_d         = g_q;
		is_req      = pkt_rdata[16];
		side_ok     = flags_sel[0] && (is_req ? flags_sel[1] : flags_sel[2]);
		fail_now    = side_ok && job.cmd.send_failed;
		new_fill    = fail_now ? fill_sel : fill_sel - FW'(1);

		case (state_q)
			S_IDLE: begin
				if (job_valid && can_emit) begin
					case (job.kind)
						rrqps_pkg::MODE_ENQ: begin
							job_ready = 1'b1;
							rsp_load  = 1'b1;
							if (!job.qp_ok || fill_sel >= FW'(QUEUE_DEPTH)) begin
								rsp_d.status = rrqps_pkg::ST_FULL;
							end else begin
								rsp_d.status = rrqps_pkg::ST_ENQ;
								pkt_we  = 1'b1;
								fill_we = 1'b1;
								fill_wd = fill_sel + FW'(1);
								pend_d  = pend_q + 8'd1;
								if (push_ok) begin
									ring_we     = 1'b1;
									ring_fill_d = ring_fill_q + (QW+1)'(1);
									onr_we      = 1'b1;
									onr_wd      = 1'b1;
								end
							end
						end
						rrqps_pkg::MODE_STAT: begin
							job_ready    = 1'b1;
							rsp_load     = 1'b1;
							flags_we     = job.qp_ok;
							rsp_d.status = rrqps_pkg::ST_STAT;
						end
						rrqps_pkg::MODE_ARB: begin
							if (ring_fill_q != '0) begin
								ring_re = 1'b1;
								state_d = S_RING;
							end else begin
								job_ready = 1'b1;
								rsp_load  = 1'b1;
							end
						end
						default: begin
							job_ready = 1'b1;
							rsp_load  = 1'b1;
						end
					endcase
				end
			end
			S_RING: begin
				if (can_emit) begin
					g_d         = ring_rdata;
					ring_head_d = (ring_head_q == QW'(NUM_QP - 1)) ? '0 :
						ring_head_q + QW'(1);
					ring_fill_d = ring_fill_q - (QW+1)'(1);
					onr_we      = 1'b1;
					onr_wd      = 1'b0;
					if (fill_sel == '0) begin
						job_ready = 1'b1;
						rsp_load  = 1'b1;
						state_d   = S_IDLE;
					end else begin
						pkt_re  = 1'b1;
						state_d = S_PKT;
					end
				end
			end
			S_PKT: begin
				if (can_emit) begin
					job_ready = 1'b1;
					rsp_load  = 1'b1;
					state_d   = S_IDLE;
					if (fail_now) begin
						fail_d       = fail_q + 32'd1;
						rsp_d.status = rrqps_pkg::ST_FAIL;
					end else begin
						head_we = 1'b1;
						fill_we = 1'b1;
						fill_wd = new_fill;
						pend_d  = pend_q - 8'd1;
						if (!side_ok) begin
							rsp_d.status = rrqps_pkg::ST_DROP;
						end else if (pkt_rdata[17]) begin
							rsp_d.status = rrqps_pkg::ST_LOOP;
						end else begin
							rsp_d.status = rrqps_pkg::ST_SENT;
						end
					end
					if (new_fill != '0 && push_ok) begin
						ring_we     = 1'b1;
						ring_fill_d = ring_fill_q + (QW+1)'(1);
						onr_we      = 1'b1;
						onr_wd      = 1'b1;
					end
					rsp_d.grant_qp         = 4'(g_q);
					rsp_d.grant_handle     = pkt_rdata[15:0];
					rsp_d.grant_is_request = pkt_rdata[16];
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		rsp_d.pending_total = pend_d;
		rsp_d.error_count   = fail_d;
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ring_head_q <= '0;
			ring_fill_q <= '0;
			pend_q      <= '0;
			fail_q      <= '0;
			g_q         <= '0;
			rsp_valid_q <= 1'b0;
			for (int i = 0; i < NUM_QP; i++) begin
				fill_q[i]    <= '0;
				head_q[i]    <= '0;
				on_ring_q[i] <= 1'b0;
				flags_q[i]   <= '0;
			end
		end else begin
			state_q     <= state_d;
			ring_head_q <= ring_head_d;
			ring_fill_q <= ring_fill_d;
			pend_q      <= pend_d;
			fail_q      <= fail_d;
			g_q         <= g_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (fill_we) begin
				fill_q[sel_q] <= fill_wd;
			end
			if (head_we) begin
				head_q[sel_q] <= head_wd;
			end
			if (onr_we) begin
				on_ring_q[sel_q] <= onr_wd;
			end
			if (flags_we) begin
				flags_q[sel_q] <= {job.cmd.resp_ready_in, job.cmd.req_ready_in,
					job.cmd.qp_valid_in};
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
endmodule

>>> hdl/round_robin_queue_pair_scheduler.sv
// Round-robin transmit scheduler over queue pairs. Enqueue and status requests are served in
// the back end's idle state, as is an arbitrate request that finds the active ring empty; any
// other arbitrate request reads the active ring memory and then, if the queue pair found there
// holds packets, the packet store memory. A two-entry request queue in the front end and a
// result register let both channels stall independently. Both memories need no clearing after
// reset, so requests are taken as soon as reset is released.
// Depends on rrqps_pkg, rrqps_if, rrqps_front and rrqps_back.
module round_robin_queue_pair_scheduler #(
	parameter int NUM_QP      = rrqps_pkg::NUM_QP_DEF,
	parameter int QUEUE_DEPTH = rrqps_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	rrqps_cmd_if.sink   cmd,
	rrqps_rsp_if.source rsp
);
	rrqps_pkg::cmd_t cmd_data;
	rrqps_pkg::job_t job;
	rrqps_pkg::rsp_t rsp_data;
	logic            job_valid;
	logic            job_ready;

	assign cmd_data = '{mode: cmd.mode, qp_index: cmd.qp_index,
		packet_handle: cmd.packet_handle, pkt_is_request: cmd.pkt_is_request,
		pkt_loopback: cmd.pkt_loopback, qp_valid_in: cmd.qp_valid_in,
		req_ready_in: cmd.req_ready_in, resp_ready_in: cmd.resp_ready_in,
		send_failed: cmd.send_failed};

	rrqps_front #(.NUM_QP(NUM_QP)) u_front (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd.valid), .cmd_ready(cmd.ready), .cmd(cmd_data),
		.job_valid(job_valid), .job_ready(job_ready), .job(job)
	);

	rrqps_back #(.NUM_QP(NUM_QP), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(job_valid), .job_ready(job_ready), .job(job),
		.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp(rsp_data)
	);

	assign rsp.status           = rsp_data.status;
	assign rsp.grant_qp         = rsp_data.grant_qp;
	assign rsp.grant_handle     = rsp_data.grant_handle;
	assign rsp.grant_is_request = rsp_data.grant_is_request;
	assign rsp.pending_total    = rsp_data.pending_total;
	assign rsp.error_count      = rsp_data.error_count;

`ifndef SYNTHESIS
	// Enqueue, full, idle and status results carry zeroed grant fields.
	a_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status == rrqps_pkg::ST_ENQ || rsp.status == rrqps_pkg::ST_FULL ||
		rsp.status == rrqps_pkg::ST_IDLE || rsp.status == rrqps_pkg::ST_STAT)
		|-> rsp.grant_qp == 4'd0 && rsp.grant_handle == 16'd0 && !rsp.grant_is_request)
		else $error("grant fields set on a result that served no packet");

	// A successful enqueue leaves at least one packet pending, unless the packet store can hold more than 255 packets.
	a_enq_pending: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == rrqps_pkg::ST_ENQ
		|-> (NUM_QP * QUEUE_DEPTH > 255) || rsp.pending_total != 8'd0)
		else $error("enqueue reported with no pending packets");
`endif
endmodule
